// ----- rtl/msort_pkg.sv -----
package msort_pkg;

   localparam int MAX_ITEMS_DEF  = 64;
   localparam int VALUE_BITS_DEF = 32;

   typedef struct packed {
      logic signed [31:0] value_in;
      logic               last_in;
   } req_data_type;

   typedef struct packed {
      logic signed [31:0] value_out;
      logic               last_out;
      logic               overflow;
   } rsp_data_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PASS,
      ST_RUN,
      ST_MERGE,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_HOLD
   } state_type;

   typedef struct packed {
      logic load_en;
      logic load_item;
      logic run_start;
      logic merge_step;
      logic next_run;
      logic next_pass;
      logic emit_start;
      logic emit_read;
      logic load_rsp;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_last;
      logic sorted;
      logic run_last;
      logic pass_last;
      logic rsp_accept;
      logic rsp_last;
   } status_type;

endpackage

// ----- rtl/msort_ctrl.sv -----
module msort_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  msort_pkg::status_type st,
   output msort_pkg::cmd_type    cmd
);

   msort_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msort_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         msort_pkg::ST_LOAD: begin
            cmd.load_en   = 1'b1;
            cmd.load_item = st.req_valid;
            if (st.req_valid && st.req_last) begin
               state_in = msort_pkg::ST_PASS;
            end
         end
         msort_pkg::ST_PASS: begin
            if (st.sorted) begin
               cmd.emit_start = 1'b1;
               state_in       = msort_pkg::ST_EMIT_RD;
            end else begin
               state_in = msort_pkg::ST_RUN;
            end
         end
         msort_pkg::ST_RUN: begin
            cmd.run_start = 1'b1;
            state_in      = msort_pkg::ST_MERGE;
         end
         msort_pkg::ST_MERGE: begin
            cmd.merge_step = 1'b1;
            if (st.run_last) begin
               if (st.pass_last) begin
                  cmd.next_pass = 1'b1;
                  state_in      = msort_pkg::ST_PASS;
               end else begin
                  cmd.next_run = 1'b1;
                  state_in     = msort_pkg::ST_RUN;
               end
            end
         end
         msort_pkg::ST_EMIT_RD: begin
            cmd.emit_read = 1'b1;
            state_in      = msort_pkg::ST_EMIT_LD;
         end
         msort_pkg::ST_EMIT_LD: begin
            cmd.load_rsp = 1'b1;
            state_in     = msort_pkg::ST_EMIT_HOLD;
         end
         msort_pkg::ST_EMIT_HOLD: begin
            if (st.rsp_accept) begin
               if (st.rsp_last) begin
                  cmd.finish = 1'b1;
                  state_in   = msort_pkg::ST_LOAD;
               end else begin
                  state_in = msort_pkg::ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = msort_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

// ----- rtl/msort_datapath.sv -----
module msort_datapath #(
   parameter int MAX_ITEMS  = msort_pkg::MAX_ITEMS_DEF,
   parameter int VALUE_BITS = msort_pkg::VALUE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  msort_pkg::req_data_type req_data,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output msort_pkg::rsp_data_type rsp_data,
   input  msort_pkg::cmd_type      cmd,
   output msort_pkg::status_type   st
);

   localparam int NW    = $clog2(MAX_ITEMS + 1);
   localparam int IW    = $clog2(MAX_ITEMS);
   localparam int SW    = NW + 2;
   localparam int AW    = IW + 1;
   localparam int DEPTH = 1 << AW;

   logic [VALUE_BITS-1:0] mem [DEPTH];
   logic [VALUE_BITS-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0]         rd_a_addr, rd_b_addr, wr_addr;
   logic [VALUE_BITS-1:0] wr_value, load_value;
   logic                  wr_en;

   logic [NW-1:0] count_ff, count_in;
   logic          dropped_ff, dropped_in;
   logic [SW-1:0] w_ff, w_in, lo_ff, lo_in;
   logic          src_ff, src_in;
   logic [NW-1:0] l_ff, l_in, r_ff, r_in, k_ff, k_in;
   logic [NW-1:0] mid_ff, mid_in, hi_ff, hi_in;
   logic          rsp_valid_ff, rsp_valid_in;
   msort_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   logic [SW-1:0] count_ext, sum_mid, sum_hi;
   logic          full, take_left, start_set;
   logic [31:0]   out_value;

   // widen or narrow the incoming value to the stored width
   if (VALUE_BITS == 32) begin : g_w_eq
      assign load_value = req_data.value_in;
      assign out_value  = rd_a_ff;
   end else if (VALUE_BITS > 32) begin : g_w_gt
      assign load_value = {{(VALUE_BITS - 32){req_data.value_in[31]}}, req_data.value_in};
      assign out_value  = rd_a_ff[31:0];
   end else begin : g_w_lt
      assign load_value = req_data.value_in[VALUE_BITS-1:0];
      assign out_value  = {{(32 - VALUE_BITS){1'b0}}, rd_a_ff};
   end

   assign count_ext = {{(SW - NW){1'b0}}, count_ff};
   assign sum_mid   = lo_ff + w_ff;
   assign sum_hi    = lo_ff + (w_ff << 1);
   assign mid_in    = (sum_mid >= count_ext) ? count_ff : sum_mid[NW-1:0];
   assign hi_in     = (sum_hi >= count_ext) ? count_ff : sum_hi[NW-1:0];
   assign full      = (count_ff == NW'(MAX_ITEMS));
   assign start_set = cmd.load_item && req_data.last_in;

   // tie goes to the right-hand run
   assign take_left = (l_ff < mid_ff) &&
                      ((r_ff >= hi_ff) || ($signed(rd_a_ff) < $signed(rd_b_ff)));

   always_comb begin
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      w_in         = w_ff;
      lo_in        = lo_ff;
      src_in       = src_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_value     = load_value;

      if (cmd.load_item) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            wr_en    = 1'b1;
            wr_addr  = {1'b0, count_ff[IW-1:0]};
            count_in = count_ff + 1'b1;
         end
      end
      if (start_set) begin
         w_in   = SW'(1);
         lo_in  = '0;
         src_in = 1'b0;
      end
      if (cmd.run_start) begin
         l_in = lo_ff[NW-1:0];
         r_in = mid_in;
         k_in = lo_ff[NW-1:0];
      end
      if (cmd.merge_step) begin
         wr_en    = 1'b1;
         wr_addr  = {~src_ff, k_ff[IW-1:0]};
         wr_value = take_left ? rd_a_ff : rd_b_ff;
         k_in     = k_ff + 1'b1;
         if (take_left) begin
            l_in = l_ff + 1'b1;
         end else begin
            r_in = r_ff + 1'b1;
         end
      end
      if (cmd.next_run) begin
         lo_in = sum_hi;
      end
      if (cmd.next_pass) begin
         lo_in  = '0;
         w_in   = w_ff << 1;
         src_in = ~src_ff;
      end
      if (cmd.emit_start) begin
         k_in = '0;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.value_out = out_value;
         rsp_data_in.last_out  = (NW'(k_ff + 1'b1) == count_ff);
         rsp_data_in.overflow  = dropped_ff;
         k_in                  = k_ff + 1'b1;
      end
      if (cmd.finish) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end
   end

   assign rd_a_addr = cmd.emit_read ? {src_ff, k_ff[IW-1:0]} : {src_ff, l_in[IW-1:0]};
   assign rd_b_addr = {src_ff, r_in[IW-1:0]};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_value;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      lo_ff       <= lo_in;
      src_ff      <= src_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
      if (cmd.run_start) begin
         mid_ff <= mid_in;
         hi_ff  <= hi_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign st.req_valid  = req_valid;
   assign st.req_last   = req_data.last_in;
   assign st.sorted     = (w_ff >= count_ext);
   assign st.run_last   = (NW'(k_ff + 1'b1) == hi_ff);
   assign st.pass_last  = (sum_hi >= count_ext);
   assign st.rsp_accept = rsp_valid_ff && !rsp_stall;
   assign st.rsp_last   = rsp_data_ff.last_out;

endmodule

// ----- rtl/merge_sorter_top.sv -----
// Loading accepts one item per cycle; the closing item starts the sort.
// Sorting: ceil(log2 n) merge passes, each made of runs merged one item at a time
// by the single compare-and-write step over the ping-pong buffer memory.
// Emitting: each sorted item goes through read, load and hand-off, and the hand-off waits under stall.
// Reset is synchronous: clears the state machine, item count, overflow flag and output valid;
// the buffer memory is not cleared.
module merge_sorter_top #(
   parameter int MAX_ITEMS  = msort_pkg::MAX_ITEMS_DEF,
   parameter int VALUE_BITS = msort_pkg::VALUE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  msort_pkg::req_data_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output msort_pkg::rsp_data_type rsp_data
);

   msort_pkg::cmd_type    cmd;
   msort_pkg::status_type st;

   msort_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   msort_datapath #(
      .MAX_ITEMS  (MAX_ITEMS),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .st        (st)
   );

   assign req_stall = ~cmd.load_en;

   // no loading while a result is pending
   a_rsp_blocks_req : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("item accepted while a result is pending");

   // delivering the final item of a set reopens the input
   a_reopen : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last_out) |=> !req_stall)
      else $error("input not reopened after final result");

   // merge writes never collide with loading or with a pending result
   a_single_write : assert property (@(posedge clock) disable iff (reset)
      cmd.merge_step |-> !cmd.load_item && !rsp_valid)
      else $error("merge step overlaps load or output");

endmodule

// ----- verif/merge_sorter_top_test.sv -----
module merge_sorter_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = msort_pkg::MAX_ITEMS_DEF;
   localparam int RANDOM_ITEMS = 150;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 100;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   msort_pkg::req_data_type req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   msort_pkg::rsp_data_type rsp_data;

   // open set as seen by the sorter, and the sorted items still to come out
   logic signed [31:0]      set_values[$];
   logic                    set_dropped = 1'b0;
   msort_pkg::rsp_data_type sorted_results[$];
   msort_pkg::rsp_data_type want;

   int  error_count = 0;
   int  result_index = 0;
   int  cycle_count = 0;
   int  random_items = 0;
   int  rsp_wait = 0;
   int  hold_cycles = 0;
   bit  no_idle = 1'b0;

   merge_sorter_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items outstanding",
                  cycle_count, sorted_results.size());
         $display("[merge_sorter_top] ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic int idle_draw();
      return no_idle ? 0 : $urandom_range(0, 8);
   endfunction

   // sort the closed set in ascending order and queue one item per stored value
   task automatic close_set();
      logic signed [31:0]      ordered[$];
      logic signed [31:0]      key;
      msort_pkg::rsp_data_type item;
      int                      j;
      ordered = set_values;
      for (int i = 1; i < ordered.size(); i++) begin
         key = ordered[i];
         j = i - 1;
         while (j >= 0 && ordered[j] > key) begin
            ordered[j + 1] = ordered[j];
            j--;
         end
         ordered[j + 1] = key;
      end
      for (int k = 0; k < ordered.size(); k++) begin
         item.value_out = ordered[k];
         item.last_out  = (k == ordered.size() - 1);
         item.overflow  = set_dropped;
         sorted_results = {sorted_results, item};
      end
      set_values.delete();
      set_dropped = 1'b0;
   endtask

   task automatic record_input(input msort_pkg::req_data_type item);
      // drop the value once the store is full, the closing one included
      if (set_values.size() < STORE_DEPTH)
         set_values = {set_values, item.value_in};
      else
         set_dropped = 1'b1;
      if (item.last_in)
         close_set();
   endtask

   task automatic send_item(input logic signed [31:0] value, input logic last);
      int                      gap;
      msort_pkg::req_data_type item;
      gap = idle_draw();
      item.value_in = value;
      item.last_in  = last;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      record_input(item);
   endtask

   function automatic logic signed [31:0] random_value();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sh0000_0000;
               default: return 32'shFFFF_FFFF;
            endcase
         end
         1, 2: return int'($urandom_range(0, 7)) - 4;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_set(input int n);
      for (int i = 0; i < n; i++)
         send_item(random_value(), i == n - 1);
   endtask

   // stop offering and hold until every sorted item is out
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sorted_results.size() != 0) @(posedge clock);
   endtask

   // receiver: a long hold-off takes priority over the per-item wait
   initial begin
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (rsp_wait > 0) begin
            rsp_stall <= 1'b1;
            rsp_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sorted_results.size() == 0) begin
            report_mismatch($sformatf("item %0d with nothing expected: value %0d",
                                      result_index, rsp_data.value_out));
         end else begin
            want = sorted_results.pop_front();
            if (rsp_data.value_out !== want.value_out)
               report_mismatch($sformatf("item %0d value_out %0d, want %0d", result_index,
                                         rsp_data.value_out, want.value_out));
            if (rsp_data.last_out !== want.last_out)
               report_mismatch($sformatf("item %0d last_out %b, want %b", result_index,
                                         rsp_data.last_out, want.last_out));
            if (rsp_data.overflow !== want.overflow)
               report_mismatch($sformatf("item %0d overflow %b, want %b", result_index,
                                         rsp_data.overflow, want.overflow));
         end
         result_index++;
         rsp_wait = idle_draw();
      end
   end

   task automatic test_extremes();
      send_item(32'sh7FFF_FFFF, 1'b0);
      send_item(32'sh8000_0000, 1'b0);
      send_item(32'sh0000_0000, 1'b0);
      send_item(32'shFFFF_FFFF, 1'b0);
      send_item(32'sh0000_0001, 1'b0);
      send_item(32'sh0001_0000, 1'b0);
      send_item(32'shFFFF_0000, 1'b0);
      send_item(32'sh7FFF_FFFE, 1'b0);
      send_item(32'sh8000_0001, 1'b1);
   endtask

   task automatic test_ties_and_order();
      // one-value set, then repeated values, then strictly descending input
      send_item(32'sh0002_8000, 1'b1);
      send_item(32'sd5, 1'b0);
      send_item(32'sd5, 1'b0);
      send_item(-32'sd3, 1'b0);
      send_item(32'sd5, 1'b0);
      send_item(-32'sd3, 1'b1);
      for (int i = 5; i >= 0; i--)
         send_item(i * 32'sh0010_0000 - 32'sh0020_0000, i == 0);
   endtask

   task automatic test_store_limit();
      send_set(STORE_DEPTH);
      // closing value lands on a full store and is dropped
      send_set(STORE_DEPTH + 1);
      send_set(STORE_DEPTH + 6);
      send_set(2);
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      for (int i = 0; i < 4; i++)
         send_set($urandom_range(1, 20));
      no_idle = 1'b0;
   endtask

   task automatic test_backpressure();
      hold_cycles = 1500;
      no_idle = 1'b1;
      for (int i = 0; i < 3; i++)
         send_set(16);
      no_idle = 1'b0;
      wait_for_results();
   endtask

   task automatic test_random();
      int pick;
      int n;
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick < 14)
            n = $urandom_range(1, 12);
         else if (pick < 18)
            n = $urandom_range(13, 40);
         else
            n = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 6);
         if ($urandom_range(0, 9) == 0)
            no_idle = 1'b1;
         send_set(n);
         no_idle = 1'b0;
         random_items += n;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_ties_and_order();
      test_store_limit();
      test_back_to_back();
      test_backpressure();
      test_random();
      wait_for_results();
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("[merge_sorter_top] OK");
      else
         $display("[merge_sorter_top] ERROR");
      $finish;
   end

endmodule
